// ----- src/color_blob_centroid_defines.svh -----
// ----------------------------------------------------------------------------
// Colour blob centroid: assertion macros
// Shared macros for the concurrent checks in the colour blob centroid block.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_CENTROID_DEFINES_SVH
`define COLOR_BLOB_CENTROID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Colour blob centroid package
// Widths, the operation codes and the request type of the shared adder.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int COLOR_W = 8;
  localparam int COORD_W = 10;
  localparam int RATIO_W = 4;
  localparam int PROD_W  = COLOR_W + RATIO_W;
  localparam int SUM_W   = 30;
  localparam int CNT_W   = 21;
  localparam int ALU_W   = 31;
  localparam int STEP_W  = $clog2(SUM_W);

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

endpackage

// ----- src/color_blob_centroid.sv -----
// ----------------------------------------------------------------------------
// Colour blob centroid
// Finds the mean position of the strongly blue pixels of each frame.
// ----------------------------------------------------------------------------
// A pixel transaction on the input stream carries red, green, blue, column and
// row in tdata and the end-of-frame mark in tlast. A pixel matches when blue is
// strictly greater than blue_ratio times red and than blue_ratio times green,
// and its coordinates lie inside MAX_WIDTH by MAX_HEIGHT; at most 2^20 matching
// pixels per frame are counted. The compares, accumulations and divisions run
// through one shared 31-bit adder under a small sequencer: a pixel that does
// not match passes through accept and two compares, one that matches also
// through three accumulations, and the input is not ready meanwhile. The last
// pixel of a frame then runs two restoring divisions of 30 steps each on the
// same adder, and an emit step hands the result to the output register. The
// result transaction carries found in tuser and the truncated mean column and
// row in tdata; both are zero when nothing matched. The output register lets
// the next frame's pixels be taken while a result still waits; only the next
// frame's result waits for it to drain. blue_ratio is written through the APB
// port at address 0 and resets to 5.
// ----------------------------------------------------------------------------
module color_blob_centroid import cbc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, lowest bit up: pixel_red, pixel_green, pixel_blue, column,
  // row_index, four zero bits
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,    // frame_end
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, lowest bit up: centroid_x, centroid_y, four zero bits
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser     // found
);

  `include "color_blob_centroid_defines.svh"

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CMP_R = 4'd1;
  localparam logic [3:0] ST_CMP_G = 4'd2;
  localparam logic [3:0] ST_ADD_X = 4'd3;
  localparam logic [3:0] ST_ADD_Y = 4'd4;
  localparam logic [3:0] ST_ADD_N = 4'd5;
  localparam logic [3:0] ST_DIV_X = 4'd6;
  localparam logic [3:0] ST_DIV_Y = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  // Register index held in the word address bit of paddr.
  localparam logic REG_BLUE_RATIO = 1'b0;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [3:0]         state;
  logic [RATIO_W-1:0] blue_ratio;

  // Pixel held while the sequencer works on it.
  logic [PROD_W-1:0]  prod_red;
  logic [PROD_W-1:0]  prod_green;
  logic [COLOR_W-1:0] blue;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               last;
  logic               in_range;
  logic               red_ok;

  // Frame accumulators.
  logic [SUM_W-1:0]   column_sum;
  logic [SUM_W-1:0]   row_sum;
  logic [CNT_W-1:0]   match_count;

  // Divider state: the dividend register shifts the quotient in from the bottom.
  logic [SUM_W-1:0]   dividend;
  logic [CNT_W-1:0]   remainder;
  logic [STEP_W-1:0]  step;
  logic [COORD_W-1:0] quo_x;

  // Output register.
  logic               out_valid;
  logic               out_found;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;

  alu_req_t           alu_req;
  logic [ALU_W:0]     alu_res;
  logic               borrow;
  logic [CNT_W:0]     trial;
  logic [SUM_W-1:0]   dividend_next;
  logic [CNT_W-1:0]   remainder_next;
  logic               is_match;
  logic               pixel_take;
  logic               out_free;

  cbc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign borrow = alu_res[ALU_W];

  // One division step: shift the next dividend bit into the partial remainder
  // and try to take the count away from it.
  assign trial          = {remainder, dividend[SUM_W-1]};
  assign dividend_next  = {dividend[SUM_W-2:0], ~borrow};
  assign remainder_next = borrow ? trial[CNT_W-1:0] : alu_res[CNT_W-1:0];

  // The count saturates at 2^20, which is its top bit set.
  assign is_match = red_ok && borrow && in_range && !match_count[CNT_W-1];

  assign pixel_take = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid || m_axis_tready;

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      ST_CMP_R: begin
        // Borrow out of ratio*red - blue means blue is the greater.
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(prod_red);
        alu_req.b  = ALU_W'(blue);
      end
      ST_CMP_G: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(prod_green);
        alu_req.b  = ALU_W'(blue);
      end
      ST_ADD_X: begin
        alu_req.a  = ALU_W'(column_sum);
        alu_req.b  = ALU_W'(col);
      end
      ST_ADD_Y: begin
        alu_req.a  = ALU_W'(row_sum);
        alu_req.b  = ALU_W'(row);
      end
      ST_ADD_N: begin
        alu_req.a  = ALU_W'(match_count);
        alu_req.b  = ALU_W'(1);
      end
      ST_DIV_X, ST_DIV_Y: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(trial);
        alu_req.b  = ALU_W'(match_count);
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  // Configuration register; writes to any other index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_ratio <= RATIO_W'(5);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLUE_RATIO) begin
      blue_ratio <= pwdata[RATIO_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLUE_RATIO) ? 32'(blue_ratio) : 32'd0;

  // Pixel capture. The two products are formed here so that the compare
  // cycles see only the adder.
  always_ff @(posedge clk) begin
    if (pixel_take) begin
      prod_red   <= PROD_W'(blue_ratio) * PROD_W'(s_axis_tdata[7:0]);
      prod_green <= PROD_W'(blue_ratio) * PROD_W'(s_axis_tdata[15:8]);
      blue       <= s_axis_tdata[23:16];
      col        <= s_axis_tdata[33:24];
      row        <= s_axis_tdata[43:34];
      last       <= s_axis_tlast;
      in_range   <= (int'(s_axis_tdata[33:24]) < MAX_WIDTH) &&
                    (int'(s_axis_tdata[43:34]) < MAX_HEIGHT);
    end
  end

  // Sequencer, accumulators and divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      column_sum  <= '0;
      row_sum     <= '0;
      match_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pixel_take) begin
            state <= ST_CMP_R;
          end
        end
        ST_CMP_R: begin
          red_ok <= borrow;
          state  <= ST_CMP_G;
        end
        ST_CMP_G: begin
          if (is_match) begin
            state <= ST_ADD_X;
          end else if (last) begin
            dividend  <= column_sum;
            remainder <= '0;
            step      <= '0;
            state     <= ST_DIV_X;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_ADD_X: begin
          column_sum <= alu_res[SUM_W-1:0];
          state      <= ST_ADD_Y;
        end
        ST_ADD_Y: begin
          row_sum <= alu_res[SUM_W-1:0];
          state   <= ST_ADD_N;
        end
        ST_ADD_N: begin
          match_count <= alu_res[CNT_W-1:0];
          if (last) begin
            dividend  <= column_sum;
            remainder <= '0;
            step      <= '0;
            state     <= ST_DIV_X;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV_X: begin
          if (step == LAST_STEP) begin
            quo_x     <= dividend_next[COORD_W-1:0];
            dividend  <= row_sum;
            remainder <= '0;
            step      <= '0;
            state     <= ST_DIV_Y;
          end else begin
            dividend  <= dividend_next;
            remainder <= remainder_next;
            step      <= step + STEP_W'(1);
          end
        end
        ST_DIV_Y: begin
          dividend  <= dividend_next;
          remainder <= remainder_next;
          step      <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // The quotients are meaningless for an empty frame, so they are
          // replaced by zero there.
          if (out_free) begin
            out_valid   <= 1'b1;
            out_found   <= (match_count != '0);
            out_x       <= (match_count != '0) ? quo_x : '0;
            out_y       <= (match_count != '0) ? dividend[COORD_W-1:0] : '0;
            column_sum  <= '0;
            row_sum     <= '0;
            match_count <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = {4'b0000, out_y, out_x};

  // Checks.
  `CBC_ASSERT_NEXT(a_take_starts_compare, clk, rst, pixel_take, state == ST_CMP_R,
                   "accepted pixel did not start the compare sequence")
  `CBC_ASSERT_SAME(a_count_below_cap, clk, rst, state == ST_ADD_N,
                   !match_count[CNT_W-1], "match count incremented beyond its cap")
  `CBC_ASSERT_NEXT(a_emit_clears, clk, rst, state == ST_EMIT && out_free,
                   match_count == '0 && state == ST_IDLE && out_valid,
                   "frame result did not clear the accumulators")
  `CBC_ASSERT_SAME(a_empty_is_zero, clk, rst, out_valid && !out_found,
                   out_x == '0 && out_y == '0, "empty frame gave a nonzero centroid")

endmodule

// ----- src/cbc_alu.sv -----
// ----------------------------------------------------------------------------
// Colour blob centroid shared adder
// One add/subtract unit; the top bit of the result is the carry or borrow.
// ----------------------------------------------------------------------------
module cbc_alu import cbc_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W:0]   res
);

  always_comb begin
    case (req.op)
      ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default: res = '0;
    endcase
  end

endmodule

// ----- bench/tb_color_blob_centroid.sv -----
// ----------------------------------------------------------------------------
// Colour blob centroid testbench
// Streams pixel frames into the block under several blue ratios and checks
// every centroid transaction against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
// The predictor applies the same integer threshold test to every accepted
// pixel, accumulates column, row and count per frame, and on the frame's last
// pixel queues the expected found flag and truncated mean position. A short
// directed part covers the threshold boundaries, the coordinate extremes, the
// empty frame, a ratio of zero and a write to an unused register index. The
// random part then runs phases at different ratios with frames of random
// length. Either side may idle in random bursts, but never in the last phase.
// ----------------------------------------------------------------------------
module tb_color_blob_centroid;
  import cbc_pkg::*;

  localparam int FRAME_W        = 1024;
  localparam int FRAME_H        = 1024;
  localparam int COUNT_CAP      = 1 << 20;
  localparam int REG_BLUE_RATIO = 0;
  localparam int REG_UNUSED     = 1;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int PHASES         = 8;
  // The last pixel of a frame keeps the block busy through its two divisions.
  localparam int SETTLE_CYCLES  = 100;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_index;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] mean_x;
    logic [COORD_W-1:0] mean_y;
  } centroid_t;

  // Holds the ratio and the running sums of the current frame, and the
  // centroids still owed by the block.
  class centroid_scoreboard;
    logic [RATIO_W-1:0] blue_ratio;
    logic [SUM_W-1:0]   column_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [CNT_W-1:0]   match_count;
    centroid_t          pending_centroids[$];
    int                 failures;
    int                 reported;

    function new();
      blue_ratio  = 4'd5;
      column_sum  = '0;
      row_sum     = '0;
      match_count = '0;
      failures    = 0;
      reported    = 0;
    endfunction

    function void write_register(int index, logic [31:0] value);
      if (index == REG_BLUE_RATIO) begin
        blue_ratio = value[RATIO_W-1:0];
      end
    endfunction

    function void take_pixel(pixel_t p);
      logic [PROD_W-1:0] red_scaled;
      logic [PROD_W-1:0] green_scaled;
      logic              hit;
      centroid_t         c;
      red_scaled   = PROD_W'(blue_ratio) * PROD_W'(p.red);
      green_scaled = PROD_W'(blue_ratio) * PROD_W'(p.green);
      hit = (PROD_W'(p.blue) > red_scaled) && (PROD_W'(p.blue) > green_scaled) &&
            (int'(p.column) < FRAME_W) && (int'(p.row_index) < FRAME_H) &&
            (int'(match_count) < COUNT_CAP);
      if (hit) begin
        column_sum  = column_sum + SUM_W'(p.column);
        row_sum     = row_sum + SUM_W'(p.row_index);
        match_count = match_count + CNT_W'(1);
      end
      if (p.frame_end) begin
        if (match_count != '0) begin
          c.found  = 1'b1;
          c.mean_x = COORD_W'(column_sum / SUM_W'(match_count));
          c.mean_y = COORD_W'(row_sum / SUM_W'(match_count));
        end else begin
          c = '0;
        end
        pending_centroids.push_back(c);
        column_sum  = '0;
        row_sum     = '0;
        match_count = '0;
      end
    endfunction

    function void compare_centroid(logic found, logic [COORD_W-1:0] mean_x,
                                   logic [COORD_W-1:0] mean_y);
      centroid_t want;
      if (pending_centroids.size() == 0) begin
        failures++;
        if (reported < 10) begin
          $display("Unexpected centroid: found %0b x %0d y %0d", found, mean_x, mean_y);
        end
        reported++;
        return;
      end
      want = pending_centroids.pop_front();
      if (found !== want.found || mean_x !== want.mean_x || mean_y !== want.mean_y) begin
        failures++;
        if (reported < 10) begin
          $display("Centroid mismatch: expected found %0b x %0d y %0d, got found %0b x %0d y %0d",
                   want.found, want.mean_x, want.mean_y, found, mean_x, mean_y);
        end
        reported++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  centroid_scoreboard sb = new();
  bit                 sender_idles = 1'b1;
  bit                 receiver_idles = 1'b1;
  int unsigned        cycle_count = 0;

  color_blob_centroid DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: the values seen here are those present at the edge, so an
  // accepted transaction is exactly one where tvalid and tready were both high.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.compare_centroid(m_axis_tuser, m_axis_tdata[COORD_W-1:0],
                          m_axis_tdata[2*COORD_W-1:COORD_W]);
    end
  end

  // Receiver back-pressure in random bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (receiver_idles && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic pixel_t make_pixel(int r, int g, int b, int x, int y, bit is_last);
    pixel_t p;
    p.red       = COLOR_W'(r);
    p.green     = COLOR_W'(g);
    p.blue      = COLOR_W'(b);
    p.column    = COORD_W'(x);
    p.row_index = COORD_W'(y);
    p.frame_end = is_last;
    return p;
  endfunction

  // Most pixels are drawn near or above the threshold for the given ratio so
  // that frames actually find something; the rest are fully random.
  function automatic pixel_t random_pixel(int ratio, bit is_last);
    pixel_t p;
    int     lim;
    int     top;
    p.red       = COLOR_W'($urandom_range(0, 255));
    p.green     = COLOR_W'($urandom_range(0, 255));
    p.blue      = COLOR_W'($urandom_range(0, 255));
    p.column    = COORD_W'($urandom_range(0, FRAME_W - 1));
    p.row_index = COORD_W'($urandom_range(0, FRAME_H - 1));
    p.frame_end = is_last;
    if ($urandom_range(0, 9) < 6) begin
      lim     = (ratio == 0) ? 255 : 254 / ratio;
      p.red   = COLOR_W'($urandom_range(0, lim));
      p.green = COLOR_W'($urandom_range(0, lim));
      top     = ratio * ((p.red > p.green) ? int'(p.red) : int'(p.green));
      // Sit exactly on the threshold or one above it now and then.
      if ($urandom_range(0, 2) == 0) begin
        p.blue = COLOR_W'(top + int'($urandom_range(0, 1)));
      end else begin
        p.blue = COLOR_W'($urandom_range(top + 1, 255));
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      p.column = COORD_W'($urandom_range(0, 1) ? FRAME_W - 1 : 0);
    end
    if ($urandom_range(0, 15) == 0) begin
      p.row_index = COORD_W'($urandom_range(0, 1) ? FRAME_H - 1 : 0);
    end
    return p;
  endfunction

  // Presents one pixel, possibly after an idle burst, and returns at the edge
  // at which the transaction is accepted. tvalid stays high on return so that
  // back-to-back pixels need no second assignment in the same step.
  task automatic send_pixel(input pixel_t p);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, p.row_index, p.column, p.blue, p.green, p.red};
    s_axis_tlast  <= p.frame_end;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_pixel(p);
  endtask

  // Setup phase, access phase, then idle with psel low so that a following
  // write starts with a clean setup phase.
  task automatic apb_write(input int index, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(index * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(index, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the pixel stream until every owed centroid has arrived, then lets
  // the block finish whatever it may still be working on.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_centroids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase_no;
    int          phase_items;
    int          frame_len;
    int          ratio;
    int          pick;
    logic [31:0] wdata;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset ratio of five. The first frame mixes the
    // all-zero pixel, full white, pixels exactly on the threshold and pixels
    // just above it, with both coordinate extremes.
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(0, 0, 255, 1023, 1023, 0));
    send_pixel(make_pixel(0, 0, 1, 0, 0, 0));
    send_pixel(make_pixel(51, 0, 255, 5, 5, 0));
    send_pixel(make_pixel(50, 50, 251, 7, 9, 0));
    send_pixel(make_pixel(0, 51, 255, 600, 400, 0));
    send_pixel(make_pixel(255, 255, 255, 300, 200, 1));
    // A one-pixel frame with no match must report nothing found.
    send_pixel(make_pixel(0, 0, 0, 1023, 1023, 1));
    // A one-pixel frame that matches at the far corner.
    send_pixel(make_pixel(0, 0, 255, 1023, 1023, 1));
    // Truncation of the mean: 2045 / 2 gives 1022.
    send_pixel(make_pixel(0, 0, 200, 1023, 0, 0));
    send_pixel(make_pixel(0, 0, 200, 1022, 1, 1));

    // A ratio of zero reduces the test to blue being non-zero.
    drain_and_settle();
    apb_write(REG_BLUE_RATIO, 32'd0);
    send_pixel(make_pixel(255, 255, 1, 3, 4, 1));
    send_pixel(make_pixel(0, 0, 0, 8, 8, 1));

    // Highest ratio, with a write to an unused register that must change nothing.
    drain_and_settle();
    apb_write(REG_BLUE_RATIO, 32'hFFFF_FFFF);
    apb_write(REG_UNUSED, 32'h0000_0003);
    send_pixel(make_pixel(17, 0, 255, 10, 10, 0));
    send_pixel(make_pixel(16, 16, 241, 20, 30, 0));
    send_pixel(make_pixel(0, 0, 15, 1023, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 0, 1023, 1));

    // Random phases: ratio one, the highest, zero, then random ones.
    // Every phase ends on a frame's last pixel so that it drains completely
    // before the ratio changes. The final phase runs without any idling.
    for (phase_no = 0; phase_no < PHASES; phase_no++) begin
      drain_and_settle();
      sender_idles   = (phase_no != PHASES - 1) && ($urandom_range(0, 3) != 0);
      receiver_idles = (phase_no != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        apb_write(REG_UNUSED, $urandom);
      end
      ratio = (phase_no == 0) ? 1 : (phase_no == 1) ? 15 : (phase_no == 2) ? 0 :
              $urandom_range(1, 15);
      wdata = $urandom;
      wdata[RATIO_W-1:0] = RATIO_W'(ratio);
      apb_write(REG_BLUE_RATIO, wdata);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / PHASES) begin
        pick = $urandom_range(0, 19);
        frame_len = (pick < 14) ? $urandom_range(1, 16) :
                    (pick < 19) ? $urandom_range(17, 64) : $urandom_range(65, 160);
        // The last frame of a phase is cut short to keep the item count.
        if (frame_len > RANDOM_ITEMS / PHASES - phase_items) begin
          frame_len = RANDOM_ITEMS / PHASES - phase_items;
        end
        for (int k = 0; k < frame_len; k++) begin
          send_pixel(random_pixel(ratio, k == frame_len - 1));
        end
        phase_items += frame_len;
      end
    end

    drain_and_settle();
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
